@@ rtl/lgr_pkg.sv @@
// shared types and constants for the two-point linear gradient ramp
// no dependencies; imported by all other rtl files but lgr_pix_if
`timescale 1ns / 1ps
`default_nettype none

package lgr_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int LANE_BITS     = 16;
  localparam int NUM_LANES     = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;

  localparam logic [CFG_IDX_BITS-1:0] REG_START_X     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Y     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_X       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_Y       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_COLOR = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_COLOR   = 3'd5;

  // which colour a channel takes
  typedef enum logic [1:0] {
    SEL_START,
    SEL_END,
    SEL_MIX
  } lgr_sel_e;

  typedef struct packed {
    lgr_sel_e sel;
    logic     degen;
  } lgr_ctl_t;

endpackage

`default_nettype wire

@@ rtl/lgr_pix_if.sv @@
// pixel coordinate request channel: valid/ready plus signed x and y
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface lgr_pix_if #(
  parameter int COORD_BITS = 15
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

@@ rtl/lgr_rgba_if.sv @@
// rgba result channel: valid/ready plus four colour channels and flags
// depends on lgr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lgr_rgba_if;
  import lgr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [LANE_BITS-1:0]          red_out;
  logic [LANE_BITS-1:0]          green_out;
  logic [LANE_BITS-1:0]          blue_out;
  logic [LANE_BITS-1:0]          alpha_out;
  logic [NUM_LANES-1:0]          channel_enable;
  logic                          degenerate;

  modport source (
    output valid, output red_out, output green_out, output blue_out,
    output alpha_out, output channel_enable, output degenerate, input ready
  );
  modport sink (
    input valid, input red_out, input green_out, input blue_out,
    input alpha_out, input channel_enable, input degenerate, output ready
  );
endinterface

`default_nettype wire

@@ rtl/lgr_divider.sv @@
// pipelined restoring divider, one quotient bit per stage, FRAC_BITS stages
// gives floor(num * 2^FRAC_BITS / den) for num < den; depends on lgr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgr_divider #(
  parameter int DEN_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          vld_i,
  input  wire logic [DEN_BITS-1:0]           num_i,
  input  wire logic [DEN_BITS-1:0]           den_i,
  input  wire lgr_pkg::lgr_ctl_t             ctl_i,
  output logic                               vld_o,
  output logic [lgr_pkg::FRAC_BITS-1:0]      quo_o,
  output lgr_pkg::lgr_ctl_t                  ctl_o
);
  import lgr_pkg::*;

  logic [DEN_BITS-1:0]  rem_q [FRAC_BITS];
  logic [DEN_BITS-1:0]  den_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_q [FRAC_BITS];
  lgr_ctl_t             ctl_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] vld_q;

  logic [DEN_BITS-1:0]  rem_in [FRAC_BITS];
  logic [DEN_BITS-1:0]  den_in [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_in [FRAC_BITS];
  lgr_ctl_t             ctl_in [FRAC_BITS];
  logic [FRAC_BITS-1:0] vld_in;
  logic [DEN_BITS:0]    rem_sh [FRAC_BITS];
  logic [DEN_BITS:0]    rem_sub [FRAC_BITS];
  logic [DEN_BITS-1:0]  rem_d [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_d [FRAC_BITS];

  always_comb begin
    rem_in[0] = num_i;
    den_in[0] = den_i;
    quo_in[0] = '0;
    ctl_in[0] = ctl_i;
    vld_in[0] = vld_i;
    for (int k = 1; k < FRAC_BITS; k++) begin
      rem_in[k] = rem_q[k-1];
      den_in[k] = den_q[k-1];
      quo_in[k] = quo_q[k-1];
      ctl_in[k] = ctl_q[k-1];
      vld_in[k] = vld_q[k-1];
    end
    for (int k = 0; k < FRAC_BITS; k++) begin
      rem_sh[k]  = {rem_in[k], 1'b0};
      rem_sub[k] = rem_sh[k] - {1'b0, den_in[k]};
      if (rem_sh[k] >= {1'b0, den_in[k]}) begin
        rem_d[k] = rem_sub[k][DEN_BITS-1:0];
        quo_d[k] = {quo_in[k][FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_d[k] = rem_sh[k][DEN_BITS-1:0];
        quo_d[k] = {quo_in[k][FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < FRAC_BITS; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_in[k];
        quo_q[k] <= quo_d[k];
        ctl_q[k] <= ctl_in[k];
      end
    end
  end

  assign vld_o = vld_q[FRAC_BITS-1];
  assign quo_o = quo_q[FRAC_BITS-1];
  assign ctl_o = ctl_q[FRAC_BITS-1];

endmodule

`default_nettype wire

@@ rtl/linear_gradient_ramp.sv @@
// Two-point linear gradient: projects each pixel onto the start-to-end vector
// and blends the start and end RGBA colours. One pixel request is taken every
// clock unless the output stalls, and results leave in order: three stages
// form the offsets, the projection products and the sums, the 16-stage divider
// pipeline makes the 16-bit ramp fraction one bit per stage, then one stage
// multiplies each colour span by the fraction and the output register rounds
// and blends. A stall on the output freezes the whole pipeline. Configuration
// registers are read directly by the offset and colour stages, so they must be
// written only while no request is in flight; the block does not enforce this.
// Depends on lgr_pkg, lgr_pix_if, lgr_rgba_if and lgr_divider.
`timescale 1ns / 1ps
`default_nettype none

module linear_gradient_ramp #(
  parameter int COORD_BITS = 15,
  parameter int COLOR_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lgr_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  wire logic [lgr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  lgr_pix_if.sink                                 pix_in,
  lgr_rgba_if.source                              rgba_out
);
  import lgr_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int DW  = 2 * COORD_BITS + 2;
  localparam int TW  = DW + 1;
  localparam int MW  = COLOR_BITS + FRAC_BITS;
  localparam int RW  = MW + 1;
  localparam logic [RW-1:0] HALF = RW'(1) << (FRAC_BITS - 1);

  // configuration
  logic signed [CB-1:0]     start_x_q, start_y_q, end_x_q, end_y_q;
  logic [CFG_DATA_BITS-1:0] start_color_q, end_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q     <= CB'(500);
      start_y_q     <= '0;
      end_x_q       <= CB'(500);
      end_y_q       <= CB'(500);
      start_color_q <= '0;
      end_color_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_X:     start_x_q     <= cfg_wdata_i[CB-1:0];
        REG_START_Y:     start_y_q     <= cfg_wdata_i[CB-1:0];
        REG_END_X:       end_x_q       <= cfg_wdata_i[CB-1:0];
        REG_END_Y:       end_y_q       <= cfg_wdata_i[CB-1:0];
        REG_START_COLOR: start_color_q <= cfg_wdata_i;
        REG_END_COLOR:   end_color_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_vld_q;

  assign adv          = !out_vld_q || rgba_out.ready;
  assign pix_in.ready = adv;

  // stage 1: offsets
  logic              v1_q;
  logic signed [CB:0] ux_q, uy_q, dx_q, dy_q;

  // stage 2: products
  logic               v2_q;
  logic signed [DW-1:0] ptx_q, pty_q, ddx_q, ddy_q;

  // stage 3: projection and squared length
  logic              v3_q;
  logic [DW-1:0]     num_q, den_q;
  lgr_ctl_t          ctl3_q;

  logic signed [TW-1:0] t_w;
  logic [DW-1:0]        den_w;
  lgr_ctl_t             ctl3_d;
  logic [DW-1:0]        num_d;

  always_comb begin
    t_w   = TW'(ptx_q) + TW'(pty_q);
    den_w = ddx_q[DW-1:0] + ddy_q[DW-1:0];
    ctl3_d.degen = (den_w == '0);
    num_d = '0;
    priority if (ctl3_d.degen || t_w <= 0) begin
      ctl3_d.sel = SEL_START;
    end else if (t_w >= $signed({1'b0, den_w})) begin
      ctl3_d.sel = SEL_END;
    end else begin
      ctl3_d.sel = SEL_MIX;
      num_d      = t_w[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pix_in.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ux_q   <= {pix_in.pixel_x[CB-1], pix_in.pixel_x} - {start_x_q[CB-1], start_x_q};
      uy_q   <= {pix_in.pixel_y[CB-1], pix_in.pixel_y} - {start_y_q[CB-1], start_y_q};
      dx_q   <= {end_x_q[CB-1], end_x_q} - {start_x_q[CB-1], start_x_q};
      dy_q   <= {end_y_q[CB-1], end_y_q} - {start_y_q[CB-1], start_y_q};
      ptx_q  <= DW'(dx_q) * DW'(ux_q);
      pty_q  <= DW'(dy_q) * DW'(uy_q);
      ddx_q  <= DW'(dx_q) * DW'(dx_q);
      ddy_q  <= DW'(dy_q) * DW'(dy_q);
      num_q  <= num_d;
      den_q  <= den_w;
      ctl3_q <= ctl3_d;
    end
  end

  // ramp fraction
  logic                 vd_w;
  logic [FRAC_BITS-1:0] quo_w;
  lgr_ctl_t             ctld_w;

  lgr_divider #(
    .DEN_BITS (DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (v3_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .ctl_i  (ctl3_q),
    .vld_o  (vd_w),
    .quo_o  (quo_w),
    .ctl_o  (ctld_w)
  );

  // per-channel span, blend and output
  logic [COLOR_BITS-1:0] lo [NUM_LANES];
  logic [COLOR_BITS-1:0] hi [NUM_LANES];
  logic [COLOR_BITS-1:0] diff [NUM_LANES];
  logic [NUM_LANES-1:0]  up;
  logic [NUM_LANES-1:0]  ena;
  logic [RW-1:0]         rnd [NUM_LANES];
  logic [COLOR_BITS-1:0] step [NUM_LANES];
  logic [COLOR_BITS-1:0] val [NUM_LANES];

  logic                  vm_q;
  logic [MW-1:0]         prod_q [NUM_LANES];
  lgr_ctl_t              ctlm_q;

  logic [LANE_BITS-1:0]  chan_q [NUM_LANES];
  logic [NUM_LANES-1:0]  ena_q;
  logic                  degen_q;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      lo[k]   = start_color_q[k*LANE_BITS +: COLOR_BITS];
      hi[k]   = end_color_q[k*LANE_BITS +: COLOR_BITS];
      up[k]   = (hi[k] >= lo[k]);
      diff[k] = up[k] ? hi[k] - lo[k] : lo[k] - hi[k];
      ena[k]  = (lo[k] != '0) || (hi[k] != '0);
      rnd[k]  = RW'(prod_q[k]) + HALF;
      step[k] = rnd[k][FRAC_BITS +: COLOR_BITS];
      unique case (ctlm_q.sel)
        SEL_START: val[k] = lo[k];
        SEL_END:   val[k] = hi[k];
        SEL_MIX:   val[k] = up[k] ? lo[k] + step[k] : lo[k] - step[k];
        default:   val[k] = lo[k];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vm_q      <= vd_w;
      out_vld_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        prod_q[k] <= MW'(diff[k]) * MW'(quo_w);
        chan_q[k] <= LANE_BITS'(val[k]);
      end
      ctlm_q  <= ctld_w;
      ena_q   <= ena;
      degen_q <= ctlm_q.degen;
    end
  end

  assign rgba_out.valid          = out_vld_q;
  assign rgba_out.red_out        = chan_q[0];
  assign rgba_out.green_out      = chan_q[1];
  assign rgba_out.blue_out       = chan_q[2];
  assign rgba_out.alpha_out      = chan_q[3];
  assign rgba_out.channel_enable = ena_q;
  assign rgba_out.degenerate     = degen_q;

endmodule

`default_nettype wire

@@ dv/linear_gradient_ramp_tb.sv @@
// self-checking testbench for linear_gradient_ramp: random and directed pixel requests
// checked against an in-bench gradient predictor; depends on lgr_pkg, lgr_pix_if,
// lgr_rgba_if and the linear_gradient_ramp rtl
`timescale 1ns / 1ps

module linear_gradient_ramp_tb;
  import lgr_pkg::*;

  localparam int COORD_W       = 15;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int HOLD_AT_PIXEL = 520;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_PIXELS  = 140;
  localparam int RAND_PHASES   = 12;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][LANE_BITS-1:0] chan;
    logic [NUM_LANES-1:0]                enable;
    logic                                degen;
  } rgba_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  lgr_pix_if #(.COORD_BITS(COORD_W)) pix_if ();
  lgr_rgba_if rgba_if ();

  linear_gradient_ramp #(
    .COORD_BITS(COORD_W),
    .COLOR_BITS(16)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pix_in     (pix_if),
    .rgba_out   (rgba_if)
  );

  // predictor copy of the ramp registers
  logic signed [COORD_W-1:0] ramp_sx, ramp_sy, ramp_ex, ramp_ey;
  logic [63:0]               ramp_c0, ramp_c1;

  pixel_t pixel_q[$];
  rgba_t  color_exp_q[$];
  int     error_cnt;
  int     pixels_done;
  int     cycle_cnt;
  int     hold_left;
  bit     hold_done;
  bit     src_gaps;
  bit     snk_gaps;
  string  lane_name [4] = '{"red", "green", "blue", "alpha"};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic rgba_t blend_pixel(pixel_t p);
    rgba_t       r;
    longint      dx, dy, den, t, frac, span, step;
    logic [15:0] lo, hi;
    int          k;
    dx = longint'(ramp_ex) - longint'(ramp_sx);
    dy = longint'(ramp_ey) - longint'(ramp_sy);
    den = dx * dx + dy * dy;
    t = dx * (longint'($signed(p.x)) - longint'(ramp_sx)) +
        dy * (longint'($signed(p.y)) - longint'(ramp_sy));
    r.degen = (den == 0);
    r.enable = '0;
    frac = 0;
    if (!r.degen && t > 0 && t < den) frac = (t * 65536) / den;
    for (k = 0; k < NUM_LANES; k++) begin
      lo = ramp_c0[LANE_BITS*k +: LANE_BITS];
      hi = ramp_c1[LANE_BITS*k +: LANE_BITS];
      r.chan[k] = '0;
      if (lo != 0 || hi != 0) begin
        r.enable[k] = 1'b1;
        if (r.degen || t <= 0) begin
          r.chan[k] = lo;
        end else if (t >= den) begin
          r.chan[k] = hi;
        end else begin
          span = (hi >= lo) ? longint'(hi) - longint'(lo) : longint'(lo) - longint'(hi);
          step = (span * frac + 32768) >>> 16;
          r.chan[k] = (hi >= lo) ? 16'(longint'(lo) + step) : 16'(longint'(lo) - step);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] coord_word(int v);
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    w[COORD_W-1:0] = v[COORD_W-1:0];
    return w;
  endfunction

  function automatic logic [63:0] rand_color();
    logic [63:0] c;
    int          k;
    for (k = 0; k < NUM_LANES; k++) begin
      case ($urandom_range(4))
        0:       c[16*k +: 16] = 16'h0000;
        1:       c[16*k +: 16] = 16'hFFFF;
        default: c[16*k +: 16] = 16'($urandom());
      endcase
    end
    return c;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_START_X:     ramp_sx = data[COORD_W-1:0];
      REG_START_Y:     ramp_sy = data[COORD_W-1:0];
      REG_END_X:       ramp_ex = data[COORD_W-1:0];
      REG_END_Y:       ramp_ey = data[COORD_W-1:0];
      REG_START_COLOR: ramp_c0 = data;
      REG_END_COLOR:   ramp_c1 = data;
      default: ;
    endcase
  endtask

  task automatic set_ramp(int sx, int sy, int ex, int ey, logic [63:0] c0, logic [63:0] c1);
    write_reg(REG_START_X, coord_word(sx));
    write_reg(REG_START_Y, coord_word(sy));
    write_reg(REG_END_X, coord_word(ex));
    write_reg(REG_END_Y, coord_word(ey));
    write_reg(REG_START_COLOR, c0);
    write_reg(REG_END_COLOR, c1);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_pixel(int x, int y);
    pixel_t p;
    p.x = x[COORD_W-1:0];
    p.y = y[COORD_W-1:0];
    pixel_q.push_back(p);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || color_exp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin : drive
    pixel_t p;
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        p.x = pix_if.pixel_x;
        p.y = pix_if.pixel_y;
        color_exp_q.push_back(blend_pixel(p));
        void'(pixel_q.pop_front());
      end
      if (pix_if.valid && !pix_if.ready) begin
        // hold the request
      end else if (pixel_q.size() != 0 && !(src_gaps && $urandom_range(99) < 9)) begin
        pix_if.valid   <= 1'b1;
        pix_if.pixel_x <= pixel_q[0].x;
        pix_if.pixel_y <= pixel_q[0].y;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : watch
    rgba_t got, want;
    int    k;
    if (!rst_n) begin
      rgba_if.ready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else begin
      if (rgba_if.valid && rgba_if.ready) begin
        got.chan   = {rgba_if.alpha_out, rgba_if.blue_out, rgba_if.green_out, rgba_if.red_out};
        got.enable = rgba_if.channel_enable;
        got.degen  = rgba_if.degenerate;
        pixels_done <= pixels_done + 1;
        if (color_exp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got);
          error_cnt++;
        end else begin
          want = color_exp_q.pop_front();
          for (k = 0; k < NUM_LANES; k++) begin
            if (got.chan[k] !== want.chan[k]) begin
              $display("%0t: %s expected %h got %h", $time, lane_name[k],
                       want.chan[k], got.chan[k]);
              error_cnt++;
            end
          end
          if (got.enable !== want.enable) begin
            $display("%0t: channel_enable expected %h got %h", $time, want.enable, got.enable);
            error_cnt++;
          end
          if (got.degen !== want.degen) begin
            $display("%0t: degenerate expected %b got %b", $time, want.degen, got.degen);
            error_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        rgba_if.ready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (pixels_done == HOLD_AT_PIXEL && !hold_done) begin
        rgba_if.ready <= 1'b0;
        hold_left     <= HOLD_CYCLES;
        hold_done     <= 1'b1;
      end else begin
        rgba_if.ready <= !(snk_gaps && $urandom_range(99) < 9);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int ph, i, u, sx, sy, ex, ey;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    pix_if.valid   = 1'b0;
    pix_if.pixel_x = '0;
    pix_if.pixel_y = '0;
    rgba_if.ready  = 1'b0;
    error_cnt      = 0;
    pixels_done    = 0;
    cycle_cnt      = 0;
    src_gaps       = 1'b1;
    snk_gaps       = 1'b1;
    // reset values of the ramp
    ramp_sx = 15'sd500;
    ramp_sy = 15'sd0;
    ramp_ex = 15'sd500;
    ramp_ey = 15'sd500;
    ramp_c0 = 64'h0;
    ramp_c1 = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset ramp: vertical, black to white
    queue_pixel(500, 0);
    queue_pixel(500, 500);
    queue_pixel(500, 250);
    queue_pixel(500, 1);
    queue_pixel(500, 499);
    queue_pixel(-16384, -16384);
    queue_pixel(16383, 16383);
    queue_pixel(0, -1);
    drain();

    // corner to corner, falling colours; spare indexes must have no effect
    write_reg(REG_SPARE_LO, {$urandom(), $urandom()});
    write_reg(REG_SPARE_HI, {$urandom(), $urandom()});
    set_ramp(-16384, -16384, 16383, 16383, '1, 64'h0);
    queue_pixel(-16384, -16384);
    queue_pixel(16383, 16383);
    queue_pixel(0, 0);
    queue_pixel(-1, 0);
    queue_pixel(16383, -16384);
    queue_pixel(-16383, -16384);
    queue_pixel(16382, 16383);
    drain();

    // degenerate ramp with two disabled channels
    set_ramp(100, -200, 100, -200, 64'h0000_1234_0000_FFFF, 64'h0000_8000_0000_0001);
    queue_pixel(100, -200);
    queue_pixel(0, 0);
    queue_pixel(16383, -16384);
    queue_pixel(-16384, 16383);
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      src_gaps = (ph != 2);
      snk_gaps = (ph != 2);
      if (ph % 2 == 0) begin
        sx = $urandom_range(32767) - 16384;
        sy = $urandom_range(32767) - 16384;
        ex = $urandom_range(32767) - 16384;
        ey = $urandom_range(32767) - 16384;
      end else begin
        sx = $urandom_range(400) - 200;
        sy = $urandom_range(400) - 200;
        ex = sx + $urandom_range(600) - 300;
        ey = sy + $urandom_range(600) - 300;
      end
      if (ph % 4 == 3) begin
        ex = sx;
        ey = sy;
      end else if (ph == 5) begin
        ex = sx;
      end else if (ph == 8) begin
        ey = sy;
      end
      set_ramp(sx, sy, ex, ey, rand_color(), rand_color());
      for (i = 0; i < PHASE_PIXELS; i++) begin
        if ($urandom_range(99) < 70) begin
          // along the ramp, a little past both ends
          u = $urandom_range(1100) - 50;
          queue_pixel(sx + ((ex - sx) * u) / 1000 + int'($urandom_range(4)) - 2,
                      sy + ((ey - sy) * u) / 1000 + int'($urandom_range(4)) - 2);
        end else begin
          queue_pixel($urandom_range(32767) - 16384, $urandom_range(32767) - 16384);
        end
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (error_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
